FILE: src/gbr_pkg.sv
package gbr_pkg;

  localparam int unsigned DisplayWidthDefault = 128;
  localparam int unsigned PageCountDefault    = 16;

  localparam int unsigned InDataWidth  = 96;
  localparam int unsigned OutDataWidth = 24;

  typedef enum logic [1:0] {
    OP_TEXT       = 2'd0,
    OP_TEXT_DBL   = 2'd1,
    OP_BITMAP     = 2'd2,
    OP_BITMAP_DBL = 2'd3
  } op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [7:0]  page_start;
    logic [7:0]  column_start;
    logic [63:0] bitmap;
    logic [7:0]  char_code;
    op_t         operation;
  } item_t;

  // column 0 in the low byte
  function automatic logic [39:0] pack5(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // 5x7 font, codes without a glyph are blank
  function automatic logic [39:0] glyph_cols(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'h2B: g = pack5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      8'h2D: g = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h30: g = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: g = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: g = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: g = pack5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: g = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: g = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: g = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: g = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: g = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h3A: g = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h3C: g = pack5(8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
      8'h3E: g = pack5(8'h00, 8'h41, 8'h22, 8'h14, 8'h08);
      8'h40: g = pack5(8'h1C, 8'h22, 8'h2E, 8'h2A, 8'h1C);
      8'h41: g = pack5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h42: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: g = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: g = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      8'h48: g = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: g = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A: g = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      8'h4B: g = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C: g = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: g = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: g = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: g = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52: g = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: g = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: g = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: g = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56: g = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'h57: g = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      8'h58: g = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: g = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5A: g = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      8'h61: g = pack5(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      8'h62: g = pack5(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
      8'h64: g = pack5(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
      8'h65: g = pack5(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      8'h68: g = pack5(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
      8'h6A: g = pack5(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
      8'h6C: g = pack5(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
      8'h6F: g = pack5(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
      8'h72: g = pack5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
      8'h75: g = pack5(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
      8'h77: g = pack5(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
      8'h79: g = pack5(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
      default: g = '0;
    endcase
    return g;
  endfunction

  // bit i goes to bits 2i and 2i+1
  function automatic logic [15:0] double_bits(input logic [7:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i]   = v[i];
      r[2*i+1] = v[i];
    end
    return r;
  endfunction

endpackage

FILE: src/gbr_column_gen.sv
module gbr_column_gen
  import gbr_pkg::*;
(
  input  op_t         operation,
  input  logic [7:0]  char_code,
  input  logic [63:0] bitmap,
  input  logic [4:0]  col_idx,
  input  logic        half,
  output logic [7:0]  pixel_byte
);

  logic [39:0] glyph;
  logic [2:0]  src_col;
  logic [7:0]  text_col;
  logic [7:0]  bm_col;
  logic [7:0]  src_byte;
  logic [15:0] dbl;
  logic        doubled;

  assign doubled = (operation == OP_TEXT_DBL) || (operation == OP_BITMAP_DBL);
  assign src_col = doubled ? col_idx[3:1] : col_idx[2:0];
  assign glyph   = glyph_cols(char_code);

  always_comb begin
    case (src_col)
      3'd0:    text_col = glyph[7:0];
      3'd1:    text_col = glyph[15:8];
      3'd2:    text_col = glyph[23:16];
      3'd3:    text_col = glyph[31:24];
      3'd4:    text_col = glyph[39:32];
      default: text_col = '0;
    endcase
  end

  // transpose: bit r is row r at pixel src_col
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      bm_col[r] = bitmap[8*r + 7 - int'(src_col)];
    end
  end

  assign src_byte = ((operation == OP_TEXT) || (operation == OP_TEXT_DBL)) ? text_col : bm_col;
  assign dbl      = double_bits(src_byte);

  always_comb begin
    if (!doubled) begin
      pixel_byte = src_byte;
    end else if (half) begin
      pixel_byte = dbl[15:8];
    end else begin
      pixel_byte = dbl[7:0];
    end
  end

endmodule

FILE: src/glyph_bitmap_page_renderer_core.sv
// glyph and bitmap page renderer
// slave side (s_*): one beat per drawing request, operation / char_code / bitmap /
// column_start / page_start packed in s_tdata.
// master side (m_*): framebuffer byte writes, page / column / pixel byte in m_tdata,
// status in m_tuser (1 = bad position, nothing written), m_tlast on the final write
// of a request.
// text gives 6 writes (clipped at the right edge), doubled text 2 x 12, bitmap 8,
// doubled bitmap 2 x 16; a bad position gives a single error beat, and text that
// starts right of the display gives no beat at all.
// a request is registered first; its writes reach m_* through the output register.
// throughput: one write per cycle while m_tready does not stall; a request has up to 32
// writes, and the output register sets the pace.
// the next request is taken in the cycle its predecessor's last write is loaded.
// reset clears the request and output valid flags; no beat is pending afterward.
// when m_tvalid and not m_tready, the output register holds and the request walk pauses.
module glyph_bitmap_page_renderer_core
  import gbr_pkg::*;
#(
  parameter int unsigned DISPLAY_WIDTH = DisplayWidthDefault,
  parameter int unsigned PAGE_COUNT    = PageCountDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // operation, char_code, bitmap, column_start, page_start, zero pad
  input  logic [InDataWidth-1:0]  s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // out_page, out_column, pixel_byte, zero pad
  output logic [OutDataWidth-1:0] m_tdata,
  // status
  output logic                    m_tuser,
  output logic                    m_tlast
);

  localparam logic [9:0] DispW = 10'(DISPLAY_WIDTH);
  localparam logic [9:0] PageN = 10'(PAGE_COUNT);

  item_t      in_item;
  logic [9:0] in_x;
  logic [9:0] in_p;
  logic [9:0] room;
  logic       x_ok;
  logic       in_dbl;
  logic [4:0] span;
  logic [4:0] in_width;
  logic       in_err;

  item_t      item;
  logic       busy;
  logic       err;
  logic       doubled;
  logic [4:0] width;
  logic [4:0] col_idx;
  logic       half;

  logic       zero;
  logic       last_beat;
  logic       adv;
  logic       done;
  logic       accept;
  logic [7:0] pixel_byte;

  assign in_item = item_t'(s_tdata[$bits(item_t)-1:0]);
  assign in_x    = {2'b00, in_item.column_start};
  assign in_p    = {2'b00, in_item.page_start};
  assign room    = DispW - in_x;
  assign x_ok    = in_x < DispW;
  assign in_dbl  = (in_item.operation == OP_TEXT_DBL) || (in_item.operation == OP_BITMAP_DBL);
  assign span    = in_dbl ? 5'd12 : 5'd6;

  always_comb begin
    case (in_item.operation)
      OP_TEXT: begin
        in_err   = in_p >= PageN;
        in_width = !x_ok ? 5'd0 : ((room >= {5'b0, span}) ? span : room[4:0]);
      end
      OP_TEXT_DBL: begin
        in_err   = (in_p + 10'd1) >= PageN;
        in_width = !x_ok ? 5'd0 : ((room >= {5'b0, span}) ? span : room[4:0]);
      end
      OP_BITMAP: begin
        in_err   = (in_p >= PageN) || ((in_x + 10'd8) > DispW);
        in_width = 5'd8;
      end
      default: begin
        in_err   = ((in_p + 10'd1) >= PageN) || ((in_x + 10'd16) > DispW);
        in_width = 5'd16;
      end
    endcase
  end

  assign zero      = !err && (width == 5'd0);
  assign last_beat = err || ((col_idx == width - 5'd1) && (half == doubled));
  assign adv       = busy && !zero && (!m_tvalid || m_tready);
  assign done      = busy && (zero || (adv && last_beat));
  assign s_tready  = !busy || done;
  assign accept    = s_tvalid && s_tready;

  gbr_column_gen u_column_gen (
    .operation  (item.operation),
    .char_code  (item.char_code),
    .bitmap     (item.bitmap),
    .col_idx    (col_idx),
    .half       (half),
    .pixel_byte (pixel_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_item;
      err     <= in_err;
      doubled <= in_dbl;
      width   <= in_width;
      col_idx <= '0;
      half    <= 1'b0;
    end else if (adv && !last_beat) begin
      if (col_idx == width - 5'd1) begin
        col_idx <= '0;
        half    <= 1'b1;
      end else begin
        col_idx <= col_idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tlast <= last_beat;
      if (err) begin
        m_tuser <= STATUS_ERR;
        m_tdata <= '0;
      end else begin
        m_tuser <= STATUS_OK;
        m_tdata <= {5'b0, pixel_byte,
                    item.column_start[6:0] + {2'b00, col_idx},
                    item.page_start[3:0] + {3'b000, half}};
      end
    end
  end

endmodule

FILE: src/gbr_checker.sv
module gbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled write beat changed");

  // an error beat ends its request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error beat without tlast");

  // an error beat carries no write
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 24'd0)
    else $error("error beat with nonzero data");

  // no beat right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("write beat out of reset");

  // while a non-final write is stalled, no new request is taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !m_tlast |-> !(s_tvalid && s_tready))
    else $error("request taken mid-walk");

endmodule

bind glyph_bitmap_page_renderer_core gbr_checker u_gbr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
